FILE: rtl/srmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srmt_pkg: shared types and constants
// Types and constants used by the sorted range map table modules.
// ----------------------------------------------------------------------------
package srmt_pkg;

	localparam int TableEntries = 64;
	localparam int IdxW = $clog2(TableEntries);
	localparam int CntW = $clog2(TableEntries + 1);
	localparam int EntryW = 96;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_HIT      = 4'd0,
		ST_MISS     = 4'd1,
		ST_INSERTED = 4'd2,
		ST_UPDATED  = 4'd3,
		ST_EXISTING = 4'd4,
		ST_OVERLAP  = 4'd5,
		ST_FULL     = 4'd6,
		ST_BAD      = 4'd7,
		ST_CLEARED  = 4'd8
	} status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] lookup_key;
		logic [31:0] range_first;
		logic [31:0] range_last;
		logic [31:0] payload_in;
	} req_item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] found_first;
		logic [31:0] found_last;
		logic [31:0] found_payload;
	} rsp_item_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load_req;
		logic search_init;
		logic search_step;
		logic rd_mid;
		logic rd_pos;
		logic shift_rd;
		logic shift_wr;
		logic wr_new;
		logic wr_pay;
		logic cnt_inc;
		logic cnt_clr;
		logic emit;
		logic [3:0] emit_status;
		logic emit_entry;
	} srmt_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		req_t req;
		logic bad_range;
		logic search_done;
		logic pos_valid;
		logic pos_hit;
		logic exact;
		logic pay_zero;
		logic full;
		logic shift_done;
	} srmt_sts_t;

endpackage
`default_nettype wire

FILE: rtl/srmt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srmt_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module srmt_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic [Width-1:0]              rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: rtl/srmt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srmt_datapath: search bounds, entry store and result register
// Holds the request, the binary search bounds, the entry RAM and the count.
// ----------------------------------------------------------------------------
module srmt_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  srmt_pkg::req_item_t     req_in,
	input  srmt_pkg::srmt_cmd_t     cmd,
	output srmt_pkg::srmt_sts_t     sts,
	output logic                    result_valid,
	output srmt_pkg::rsp_item_t     result
);
	localparam int IW = srmt_pkg::IdxW;
	localparam int CW = srmt_pkg::CntW;

	srmt_pkg::req_item_t req_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] mid;
	logic [CW-1:0] shift_q;
	logic [IW-1:0] addr;
	logic          we;
	logic [srmt_pkg::EntryW-1:0] wdata;
	logic [srmt_pkg::EntryW-1:0] rdata;
	logic [31:0] r_first, r_last, r_pay, key;
	logic [CW:0] sum;

	assign sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = sum[CW:1];
	assign {r_first, r_last, r_pay} = rdata;
	assign key = (req_q.req_type == srmt_pkg::REQ_LOOKUP) ? req_q.lookup_key
		: req_q.range_first;

	always_comb begin
		we = 1'b0;
		addr = mid[IW-1:0];
		wdata = rdata;
		if (cmd.shift_rd) begin
			addr = IW'(shift_q - CW'(1));
		end else if (cmd.shift_wr) begin
			we = 1'b1;
			addr = shift_q[IW-1:0];
		end else if (cmd.wr_new) begin
			we = 1'b1;
			addr = lo_q[IW-1:0];
			wdata = {req_q.range_first, req_q.range_last, req_q.payload_in};
		end else if (cmd.wr_pay) begin
			we = 1'b1;
			addr = lo_q[IW-1:0];
			wdata = {r_first, r_last, req_q.payload_in};
		end else if (cmd.rd_pos) begin
			addr = lo_q[IW-1:0];
		end else if (cmd.rd_mid) begin
			addr = mid[IW-1:0];
		end
	end

	srmt_ram #(.Width(srmt_pkg::EntryW), .Depth(srmt_pkg::TableEntries)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// Search finds the first entry whose last key is not below the key.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_in;
		end
		if (cmd.search_init) begin
			lo_q <= '0;
			hi_q <= count_q;
			shift_q <= count_q;
		end else if (cmd.search_step) begin
			if (r_last < key) begin
				lo_q <= mid + CW'(1);
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.shift_wr) begin
			shift_q <= shift_q - CW'(1);
		end
		if (cmd.emit) begin
			result.status <= cmd.emit_status;
			if (cmd.emit_entry) begin
				result.found_first <= r_first;
				result.found_last <= r_last;
				result.found_payload <= cmd.wr_pay ? req_q.payload_in : r_pay;
			end else if (cmd.wr_new) begin
				result.found_first <= req_q.range_first;
				result.found_last <= req_q.range_last;
				result.found_payload <= req_q.payload_in;
			end else begin
				result.found_first <= '0;
				result.found_last <= '0;
				result.found_payload <= '0;
			end
		end
	end

	always_comb begin
		sts.req = srmt_pkg::req_t'(req_q.req_type);
		sts.bad_range = req_q.range_first > req_q.range_last;
		sts.search_done = lo_q == hi_q;
		sts.pos_valid = lo_q < count_q;
		sts.pos_hit = (req_q.req_type == srmt_pkg::REQ_LOOKUP)
			? (r_first <= req_q.lookup_key) : (r_first <= req_q.range_last);
		sts.exact = (r_first == req_q.range_first) && (r_last == req_q.range_last);
		sts.pay_zero = req_q.payload_in == 32'd0;
		sts.full = count_q == CW'(srmt_pkg::TableEntries);
		sts.shift_done = shift_q == lo_q;
	end

	as_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(srmt_pkg::TableEntries))
		else $error("entry count above table size");
	as_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search_step |-> lo_q < hi_q)
		else $error("search step with empty interval");
	as_inc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !sts.full)
		else $error("insert into full table");
endmodule
`default_nettype wire

FILE: rtl/srmt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srmt_ctrl: request sequencer
// Steps a request through search, shift and result phases.
// ----------------------------------------------------------------------------
module srmt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  srmt_pkg::srmt_sts_t sts,
	output srmt_pkg::srmt_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_SEARCH, S_WAIT, S_POS, S_READ, S_SHIFT, S_INSERT
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.load_req = start && !busy;
		unique case (state_q)
			S_IDLE: begin
			end
			S_DECODE: begin
				cmd.search_init = 1'b1;
				unique case (sts.req)
					srmt_pkg::REQ_CLEAR: begin
						cmd.cnt_clr = 1'b1;
						cmd.emit = 1'b1;
						cmd.emit_status = srmt_pkg::ST_CLEARED;
					end
					srmt_pkg::REQ_NONE: begin
						cmd.emit = 1'b1;
						cmd.emit_status = srmt_pkg::ST_MISS;
					end
					srmt_pkg::REQ_INSERT: begin
						if (sts.bad_range) begin
							cmd.emit = 1'b1;
							cmd.emit_status = srmt_pkg::ST_BAD;
						end
					end
					srmt_pkg::REQ_LOOKUP: begin
					end
				endcase
			end
			S_SEARCH: begin
				if (!sts.search_done) begin
					cmd.rd_mid = 1'b1;
				end
			end
			S_WAIT: cmd.search_step = 1'b1;
			S_POS: cmd.rd_pos = 1'b1;
			S_READ: begin
				cmd.emit = 1'b1;
				if (sts.req == srmt_pkg::REQ_LOOKUP) begin
					cmd.emit_entry = sts.pos_valid && sts.pos_hit;
					cmd.emit_status = cmd.emit_entry ? srmt_pkg::ST_HIT : srmt_pkg::ST_MISS;
				end else if (sts.pos_valid && sts.pos_hit) begin
					if (sts.exact) begin
						cmd.emit_entry = 1'b1;
						cmd.wr_pay = !sts.pay_zero;
						cmd.emit_status = sts.pay_zero ? srmt_pkg::ST_EXISTING
							: srmt_pkg::ST_UPDATED;
					end else begin
						cmd.emit_status = srmt_pkg::ST_OVERLAP;
					end
				end else if (sts.full) begin
					cmd.emit_status = srmt_pkg::ST_FULL;
				end else begin
					cmd.emit = 1'b0;
				end
			end
			S_SHIFT: begin
				if (!sts.shift_done) begin
					cmd.shift_rd = 1'b1;
				end
			end
			S_INSERT: begin
				if (sts.shift_done) begin
					cmd.wr_new = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.emit = 1'b1;
					cmd.emit_status = srmt_pkg::ST_INSERTED;
				end else begin
					cmd.shift_wr = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DECODE;
						busy <= 1'b1;
					end
				end
				S_DECODE: begin
					if (cmd.emit) begin
						state_q <= S_IDLE;
						busy <= 1'b0;
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: state_q <= sts.search_done ? S_POS : S_WAIT;
				S_WAIT: state_q <= S_SEARCH;
				S_POS: state_q <= S_READ;
				S_READ: begin
					if (cmd.emit) begin
						state_q <= S_IDLE;
						busy <= 1'b0;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: state_q <= S_INSERT;
				S_INSERT: begin
					if (sts.shift_done) begin
						state_q <= S_IDLE;
						busy <= 1'b0;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy <= 1'b0;
				end
			endcase
		end
	end

	as_busy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy == (state_q != S_IDLE))
		else $error("busy disagrees with state");
	as_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !busy)
		else $error("result emitted but request not retired");
	as_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.shift_wr, cmd.wr_new, cmd.wr_pay}) <= 1)
		else $error("conflicting RAM writes");
endmodule
`default_nettype wire

FILE: rtl/sorted_range_map_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_range_map_table_core: sorted range map table
// Binary search over a sorted table of disjoint ranges with insert and clear.
//
//   Channel   Handshake              Payload
//   request   start, busy            req (req_item_t)
//   result    result_valid strobe    result (rsp_item_t)
//
// A lookup runs a binary search in which the single RAM port serves each search
// probe with a registered read, then reads the found position and answers.
// An insert that adds an entry also moves each entry above the position up by
// one, with a read and a write per entry, before it writes the new entry.
// Clear, bad range and the unused type answer from the decode state.
// The result strobe lasts one cycle. Reset empties the table; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_range_map_table_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  srmt_pkg::req_item_t req,
	output logic               result_valid,
	output srmt_pkg::rsp_item_t result
);
	srmt_pkg::srmt_cmd_t cmd;
	srmt_pkg::srmt_sts_t sts;

	srmt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	srmt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .req_in(req), .cmd(cmd), .sts(sts),
		.result_valid(result_valid), .result(result)
	);
endmodule
`default_nettype wire
